FILE: rtl/cpd_pkg.sv
`timescale 1ns / 1ps

package cpd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CrcW  = 16;

	localparam logic [CrcW-1:0]  CrcInit       = 16'hFFFF;
	localparam logic [ByteW-1:0] StartByteRst  = 8'hA1;
	localparam logic [ByteW-1:0] MaxLengthRst  = 8'd200;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 8;
	localparam logic [CfgIdxW-1:0] CfgStartByte = 8'd0;
	localparam logic [CfgIdxW-1:0] CfgMaxLength = 8'd1;

	// output tdata / tuser layout
	localparam int unsigned TdataW = 4 * ByteW;
	localparam int unsigned TuserW = 2;

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_TYPE    = 6'b000010,
		PH_LEN     = 6'b000100,
		PH_CRC_LO  = 6'b001000,
		PH_CRC_HI  = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] byte_index;
		logic [ByteW-1:0] data_byte;
		logic [ByteW-1:0] pkt_length;
		logic [ByteW-1:0] pkt_type;
	} out_data_t;

	// one byte through the reflected 0x8408 crc, table-free form
	function automatic logic [CrcW-1:0] crc_feed(input logic [ByteW-1:0] b,
			input logic [CrcW-1:0] crc);
		logic [ByteW-1:0] x;
		logic [CrcW-1:0]  xw;
		x  = b ^ crc[7:0];
		x  = x ^ {x[3:0], 4'b0000};
		xw = {8'h00, x};
		return {x, crc[15:8]} ^ (xw >> 4) ^ (xw << 3);
	endfunction

endpackage

FILE: rtl/crc_packet_deframer.sv
`timescale 1ns / 1ps

// crc_packet_deframer
// input stream (s_*): one received byte per transaction on s_tdata
// output stream (m_*): one transaction per payload byte, plus an end-only
//   transaction (tuser has_data = 0) for a packet of zero length; tlast marks
//   the final transaction of a packet and tuser crc_ok is valid with it
// packet layout: start byte, type, length, crc low, crc high, payload
// lengths above max_length abort the header and return to hunting
// configuration port (cfg_*): index 0 start byte, index 1 max length;
//   always ready, other indexes are ignored; write only while idle
// each result is registered and appears on m_* in the cycle after its input transaction
// throughput is one byte per cycle when not stalled, set by the single registered phase step
//   (phase machine plus one-byte crc update between state and output register)
// reset: hunting, crc at 0xFFFF, output register empty, registers at
//   start byte 0xA1 and max length 200
// stall: while the output register is full and m_tready is low the input
//   stops taking bytes; it resumes in the cycle the result is taken
module crc_packet_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cpd_pkg::ByteW-1:0]       s_tdata,   // rx_byte
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cpd_pkg::TdataW-1:0]      m_tdata,   // pkt_type, pkt_length, data_byte, byte_index
	output logic                            m_tlast,   // last
	output logic [cpd_pkg::TuserW-1:0]      m_tuser,   // has_data, crc_ok
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cpd_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [cpd_pkg::ByteW-1:0]       cfg_data
);

	// configuration registers
	logic [cpd_pkg::ByteW-1:0] start_byte_q;
	logic [cpd_pkg::ByteW-1:0] max_length_q;

	// packet state
	cpd_pkg::phase_t           phase_q, phase_d;
	logic [cpd_pkg::ByteW-1:0] type_q, type_d;
	logic [cpd_pkg::ByteW-1:0] len_q, len_d;
	logic [cpd_pkg::CrcW-1:0]  rx_crc_q, rx_crc_d;
	logic [cpd_pkg::CrcW-1:0]  crc_q, crc_d;
	logic [cpd_pkg::ByteW-1:0] cnt_q, cnt_d;

	// output register
	logic                      out_valid_q;
	cpd_pkg::out_data_t        out_data_q, out_data_d;
	logic                      out_last_q, out_last_d;
	logic                      out_has_q, out_has_d;
	logic                      out_ok_q, out_ok_d;
	logic                      emit_d;

	logic                      in_acc;
	logic [cpd_pkg::CrcW-1:0]  crc_in;
	logic [cpd_pkg::CrcW-1:0]  crc_upd;
	logic [cpd_pkg::CrcW-1:0]  rx_crc_full;
	logic [cpd_pkg::ByteW-1:0] cnt_inc;

	// output register frees up when empty or being taken this cycle
	assign s_tready  = !out_valid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// the type byte restarts the crc from its initial value
	assign crc_in      = (phase_q == cpd_pkg::PH_TYPE) ? cpd_pkg::CrcInit : crc_q;
	assign crc_upd     = cpd_pkg::crc_feed(s_tdata, crc_in);
	assign rx_crc_full = {s_tdata, rx_crc_q[7:0]};
	assign cnt_inc     = cnt_q + 8'd1;

	// phase step for one byte
	always_comb begin
		phase_d    = phase_q;
		type_d     = type_q;
		len_d      = len_q;
		rx_crc_d   = rx_crc_q;
		crc_d      = crc_q;
		cnt_d      = cnt_q;
		emit_d     = 1'b0;
		out_data_d = '{pkt_type: type_q, pkt_length: len_q, data_byte: '0, byte_index: '0};
		out_last_d = 1'b0;
		out_has_d  = 1'b0;
		out_ok_d   = 1'b0;
		unique case (phase_q)
			cpd_pkg::PH_TYPE: begin
				type_d  = s_tdata;
				crc_d   = crc_upd;
				phase_d = cpd_pkg::PH_LEN;
			end
			cpd_pkg::PH_LEN: begin
				len_d   = s_tdata;
				crc_d   = crc_upd;
				phase_d = (s_tdata <= max_length_q) ? cpd_pkg::PH_CRC_LO : cpd_pkg::PH_HUNT;
			end
			cpd_pkg::PH_CRC_LO: begin
				rx_crc_d = {8'h00, s_tdata};
				phase_d  = cpd_pkg::PH_CRC_HI;
			end
			cpd_pkg::PH_CRC_HI: begin
				rx_crc_d = rx_crc_full;
				cnt_d    = '0;
				if (len_q == '0) begin
					// empty packet: end-only result
					phase_d    = cpd_pkg::PH_HUNT;
					emit_d     = 1'b1;
					out_last_d = 1'b1;
					out_ok_d   = (rx_crc_full == crc_q);
				end else begin
					phase_d = cpd_pkg::PH_PAYLOAD;
				end
			end
			cpd_pkg::PH_PAYLOAD: begin
				crc_d                 = crc_upd;
				cnt_d                 = cnt_inc;
				emit_d                = 1'b1;
				out_has_d             = 1'b1;
				out_data_d.data_byte  = s_tdata;
				out_data_d.byte_index = cnt_q;
				if (cnt_inc == len_q) begin
					phase_d    = cpd_pkg::PH_HUNT;
					out_last_d = 1'b1;
					out_ok_d   = (rx_crc_q == crc_upd);
				end
			end
			default: begin
				// hunting, start byte inside a packet is never looked for
				phase_d = (s_tdata == start_byte_q) ? cpd_pkg::PH_TYPE : cpd_pkg::PH_HUNT;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= cpd_pkg::StartByteRst;
			max_length_q <= cpd_pkg::MaxLengthRst;
		end else if (cfg_valid) begin
			if (cfg_index == cpd_pkg::CfgStartByte) begin
				start_byte_q <= cfg_data;
			end else if (cfg_index == cpd_pkg::CfgMaxLength) begin
				max_length_q <= cfg_data;
			end
		end
	end

	// packet state, advanced once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cpd_pkg::PH_HUNT;
			type_q   <= '0;
			len_q    <= '0;
			rx_crc_q <= '0;
			crc_q    <= cpd_pkg::CrcInit;
			cnt_q    <= '0;
		end else if (in_acc) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			len_q    <= len_d;
			rx_crc_q <= rx_crc_d;
			crc_q    <= crc_d;
			cnt_q    <= cnt_d;
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= in_acc && emit_d;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_acc && emit_d) begin
			out_data_q <= out_data_d;
			out_last_q <= out_last_d;
			out_has_q  <= out_has_d;
			out_ok_q   <= out_ok_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ok_q, out_has_q};

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	// every payload byte taken yields a result in the next cycle
	a_payload_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == cpd_pkg::PH_PAYLOAD) |=> (out_valid_q && out_has_q))
		else $error("payload byte produced no result");

	// a packet end sends the phase machine back to hunting
	a_last_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && emit_d && out_last_d) |=> (phase_q == cpd_pkg::PH_HUNT))
		else $error("phase not back to hunting after packet end");

	// payload count stays below the held length while in payload
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == cpd_pkg::PH_PAYLOAD) |-> (cnt_q < len_q))
		else $error("payload count ran past length");

	// crc_ok only ever set on a final result
	a_ok_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ok_q) |-> out_last_q)
		else $error("crc_ok set on a non-final result");

endmodule
